### rtl/efws_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// efws_pkg
// shared widths, heap slot type and ordering function for the scheduler
// ----------------------------------------------------------------------------
package efws_pkg;

  localparam int TIME_W          = 48;
  localparam int DUR_W           = 32;
  localparam int WKR_W           = 6;
  localparam int CNT_W           = 7;
  // worker count register is 7 bits, so live workers never exceed 127
  localparam int IDX_W           = 7;
  localparam int DEF_MAX_WORKERS = 64;

  typedef struct packed {
    logic [TIME_W-1:0] time_v;
    logic [IDX_W-1:0]  idx;
  } slot_t;

  typedef struct packed {
    logic swap;   // a child is earlier than the moving slot
    logic right;  // that child is the right one
  } pick_t;

  // strict order: time first, lower index on equal time
  function automatic logic earlier(input slot_t a, input slot_t b);
    logic res;
    if (a.time_v != b.time_v) begin
      res = (a.time_v < b.time_v);
    end else begin
      res = (a.idx < b.idx);
    end
    return res;
  endfunction

endpackage

### rtl/earliest_free_worker_scheduler_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// earliest_free_worker_scheduler_core
// binary min-heap of workers keyed by next-free time; each job beat takes the
// earliest free worker, reports it with its start time and sifts it back down
// ----------------------------------------------------------------------------
//
//  channel | dir | handshake            | payload
//  --------+-----+----------------------+-----------------------------------
//  in_     | in  | in_tvalid/in_tready  | in_tdata[31:0]  duration
//  out_    | out | out_tvalid/out_tready| out_tdata[5:0] worker,
//          |     |                      | out_tdata[53:6] start_time
//  cfg_    | in  | cfg_wen              | cfg_wdata[6:0]  worker_count
//
//  a job beat is accepted in idle and the block is ready again once the
//  worker settles at heap level d (d <= floor(log2 live workers)): the root
//  is read, then the result and the add are formed (waiting while the output
//  register is full), then one level is compared at a time in the shared
//  compare unit against the single write / dual read heap memory
//  after reset and after each worker_count write a clearing pass writes all
//  MAX_WORKERS heap entries, one a cycle, with in_tready low meanwhile
//  a result waits in the output register; a stalled output holds the next
//  job at the root stage, jobs are still taken while the register is full
//
module earliest_free_worker_scheduler_core #(
  parameter int MAX_WORKERS = efws_pkg::DEF_MAX_WORKERS
) (
  input  logic                      clk,
  input  logic                      rst_n,
  // duration
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic [31:0]               in_tdata,
  // worker (lowest), start_time
  output logic                      out_tvalid,
  input  logic                      out_tready,
  output logic [55:0]               out_tdata,
  // worker_count
  input  logic                      cfg_wen,
  input  logic [efws_pkg::CNT_W-1:0] cfg_wdata
);
  import efws_pkg::*;

  localparam int ADDR_W = (MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1;
  localparam int LIVE_W = $clog2(MAX_WORKERS + 1);
  localparam int CW     = ADDR_W + 2;

  // sequencer codes
  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_RROOT = 3'd2;
  localparam logic [2:0] ST_ROOT  = 3'd3;
  localparam logic [2:0] ST_SIFT  = 3'd4;

  // heap memory, one write port and two registered read ports
  slot_t heap_mem [MAX_WORKERS];

  logic [2:0]        state_r, state_nxt;
  logic [ADDR_W-1:0] clr_cnt_r, clr_cnt_nxt;
  logic [LIVE_W-1:0] live_r, live_nxt;
  logic [ADDR_W-1:0] at_r, at_nxt;
  slot_t             cur_r, cur_nxt;
  logic [DUR_W-1:0]  dur_r, dur_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [WKR_W-1:0]  out_worker_r, out_worker_nxt;
  logic [TIME_W-1:0] out_start_r, out_start_nxt;

  slot_t             rd_a_r, rd_b_r;
  logic              rd_en;
  logic              rd_root;
  logic [ADDR_W-1:0] rd_a_addr, rd_b_addr;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  slot_t             wr_data;

  logic [CW-1:0]     at_ext, l_full, r_full;
  logic [CW-1:0]     nat_ext, nl_full, nr_full;
  logic [CW-1:0]     live_ext;
  logic              l_ok, r_ok;
  pick_t             pick;
  logic [TIME_W:0]   sum;
  logic [TIME_W-1:0] next_time;
  logic [31:0]       cnt32;

  // children of the node being compared
  assign at_ext   = CW'(at_r);
  assign l_full   = (at_ext << 1) + CW'(1);
  assign r_full   = (at_ext << 1) + CW'(2);
  assign live_ext = CW'(live_r);
  assign l_ok     = (l_full < live_ext);
  assign r_ok     = (r_full < live_ext);

  // children of the node to be compared next
  assign nat_ext  = CW'(at_nxt);
  assign nl_full  = (nat_ext << 1) + CW'(1);
  assign nr_full  = (nat_ext << 1) + CW'(2);

  assign rd_a_addr = rd_root ? '0 : nl_full[ADDR_W-1:0];
  assign rd_b_addr = nr_full[ADDR_W-1:0];

  efws_pick u_pick (
    .cur   (cur_r),
    .left  (rd_a_r),
    .right (rd_b_r),
    .l_ok  (l_ok),
    .r_ok  (r_ok),
    .pick  (pick)
  );

  // new free time of the popped worker, saturating
  assign sum       = {1'b0, rd_a_r.time_v} + (TIME_W+1)'(dur_r);
  assign next_time = sum[TIME_W] ? {TIME_W{1'b1}} : sum[TIME_W-1:0];

  // worker count clamped to 1..MAX_WORKERS
  always_comb begin
    cnt32 = 32'(cfg_wdata);
    priority if (cnt32 == 32'd0) begin
      cnt32 = 32'd1;
    end else if (cnt32 > 32'(MAX_WORKERS)) begin
      cnt32 = 32'(MAX_WORKERS);
    end else begin
      cnt32 = 32'(cfg_wdata);
    end
  end

  always_comb begin
    state_nxt      = state_r;
    clr_cnt_nxt    = clr_cnt_r;
    live_nxt       = live_r;
    at_nxt         = at_r;
    cur_nxt        = cur_r;
    dur_nxt        = dur_r;
    out_worker_nxt = out_worker_r;
    out_start_nxt  = out_start_r;
    out_valid_nxt  = out_valid_r & ~out_tready;
    rd_en          = 1'b0;
    rd_root        = 1'b0;
    wr_en          = 1'b0;
    wr_addr        = at_r;
    wr_data        = cur_r;

    unique case (state_r)
      ST_CLEAR: begin
        // entry i holds worker i, free at time zero
        wr_en          = 1'b1;
        wr_addr        = clr_cnt_r;
        wr_data.time_v = '0;
        wr_data.idx    = IDX_W'(clr_cnt_r);
        clr_cnt_nxt    = clr_cnt_r + ADDR_W'(1);
        if (clr_cnt_r == ADDR_W'(MAX_WORKERS - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_tvalid) begin
          dur_nxt   = in_tdata[DUR_W-1:0];
          state_nxt = ST_RROOT;
        end
      end
      ST_RROOT: begin
        rd_en     = 1'b1;
        rd_root   = 1'b1;
        state_nxt = ST_ROOT;
      end
      ST_ROOT: begin
        // root data sits in port a; wait for room in the output register
        if (!out_valid_r || out_tready) begin
          out_valid_nxt  = 1'b1;
          out_worker_nxt = WKR_W'(rd_a_r.idx);
          out_start_nxt  = rd_a_r.time_v;
          cur_nxt.time_v = next_time;
          cur_nxt.idx    = rd_a_r.idx;
          at_nxt         = '0;
          rd_en          = 1'b1;
          state_nxt      = ST_SIFT;
        end
      end
      ST_SIFT: begin
        wr_en = 1'b1;
        if (pick.swap) begin
          // earlier child moves up into the hole, hole moves down
          wr_data   = pick.right ? rd_b_r : rd_a_r;
          at_nxt    = pick.right ? r_full[ADDR_W-1:0] : l_full[ADDR_W-1:0];
          rd_en     = 1'b1;
        end else begin
          wr_data   = cur_r;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase

    // a count write reloads the heap
    if (cfg_wen) begin
      live_nxt    = LIVE_W'(cnt32);
      clr_cnt_nxt = '0;
      state_nxt   = ST_CLEAR;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      live_r      <= LIVE_W'(1);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      live_r      <= live_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    at_r         <= at_nxt;
    cur_r        <= cur_nxt;
    dur_r        <= dur_nxt;
    out_worker_r <= out_worker_nxt;
    out_start_r  <= out_start_nxt;
  end

  // heap memory
  always_ff @(posedge clk) begin
    if (wr_en) begin
      heap_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_a_r <= heap_mem[rd_a_addr];
      rd_b_r <= heap_mem[rd_b_addr];
    end
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_start_r, out_worker_r};

  // the sift position always stays inside the live heap
  a_at_live: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SIFT) |-> (at_ext < live_ext))
    else $error("sift position beyond live workers");

  // live worker count stays in 1..MAX_WORKERS
  a_live_rng: assert property (@(posedge clk) disable iff (!rst_n)
    (live_r != '0) && (32'(live_r) <= 32'(MAX_WORKERS)))
    else $error("live worker count out of range");

  // a count write blocks jobs in the following cycle
  a_cfg_clear: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_wen |=> !in_tready)
    else $error("job taken right after count write");

  // a pending result is never overwritten by the next job
  a_root_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ROOT && out_valid_r && !out_tready && !cfg_wen)
      |=> (state_r == ST_ROOT))
    else $error("root stage left while output stalled");

endmodule

### rtl/efws_pick.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// efws_pick
// shared compare unit: picks the earliest of a slot and its two children
// ----------------------------------------------------------------------------
module efws_pick (
  input  efws_pkg::slot_t cur,
  input  efws_pkg::slot_t left,
  input  efws_pkg::slot_t right,
  input  logic            l_ok,
  input  logic            r_ok,
  output efws_pkg::pick_t pick
);
  import efws_pkg::*;

  slot_t best;

  always_comb begin
    best       = cur;
    pick.swap  = 1'b0;
    pick.right = 1'b0;
    if (l_ok && earlier(left, cur)) begin
      best      = left;
      pick.swap = 1'b1;
    end
    if (r_ok && earlier(right, best)) begin
      pick.swap  = 1'b1;
      pick.right = 1'b1;
    end
  end

endmodule

### dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the earliest-free worker scheduler: a scoreboard
// keeps its own worker heap, predicts the worker and start time of every
// accepted job beat and matches them in order against the result beats, while
// the job sender runs in random bursts and the result side stalls on its own
// ----------------------------------------------------------------------------
module tb_top;
  import efws_pkg::*;

  localparam int WORKERS       = DEF_MAX_WORKERS;
  localparam int BEAT_W        = 56;
  localparam int HOLD_CYCLES   = 300;
  localparam int QUIET_LIMIT   = 4000;
  localparam int SETTLE_CYCLES = 16;
  localparam int RANDOM_JOBS   = 1500;

  localparam logic [TIME_W-1:0] TIME_CEIL = '1;
  localparam logic [DUR_W-1:0]  DUR_MAX   = '1;

  typedef struct packed {
    logic [TIME_W-1:0] free_at;
    logic [WKR_W-1:0]  worker;
  } crew_slot_t;

  typedef struct packed {
    logic [WKR_W-1:0]  worker;
    logic [TIME_W-1:0] start_time;
  } grant_t;

  // keeps its own heap of workers and the grants still owed by the block
  class dispatch_scoreboard;
    crew_slot_t  crew[WORKERS];
    int unsigned live;
    grant_t      grants_due[$];
    int unsigned mismatches;
    int unsigned jobs_seen;

    function new();
      load_count(CNT_W'(1));
    endfunction

    // zero counts as one worker, anything above the heap size is clamped
    function void load_count(input logic [CNT_W-1:0] value);
      int unsigned n;
      n = 32'(value);
      if (n == 0) n = 1;
      if (n > WORKERS) n = WORKERS;
      live = n;
      for (int i = 0; i < WORKERS; i++) begin
        crew[i].free_at = '0;
        crew[i].worker  = WKR_W'(i);
      end
    endfunction

    function bit precedes(input crew_slot_t a, input crew_slot_t b);
      if (a.free_at != b.free_at) return a.free_at < b.free_at;
      return a.worker < b.worker;
    endfunction

    function void take_job(input logic [DUR_W-1:0] duration);
      logic [TIME_W:0] finish_at;
      grant_t          g;
      crew_slot_t      moving;
      int unsigned     at, best, kid;
      bit              settled;
      g.worker     = crew[0].worker;
      g.start_time = crew[0].free_at;
      grants_due.push_back(g);
      jobs_seen++;
      finish_at = {1'b0, crew[0].free_at} + (TIME_W+1)'(duration);
      crew[0].free_at = finish_at[TIME_W] ? TIME_CEIL : finish_at[TIME_W-1:0];
      // sift the root back down among the live workers
      at      = 0;
      settled = 1'b0;
      while (!settled) begin
        best = at;
        kid  = 2 * at + 1;
        if (kid < live && precedes(crew[kid], crew[best])) best = kid;
        kid  = 2 * at + 2;
        if (kid < live && precedes(crew[kid], crew[best])) best = kid;
        if (best == at) begin
          settled = 1'b1;
        end else begin
          moving     = crew[at];
          crew[at]   = crew[best];
          crew[best] = moving;
          at         = best;
        end
      end
    endfunction

    function void match_grant(input logic [BEAT_W-1:0] beat);
      grant_t            want;
      logic [WKR_W-1:0]  got_worker;
      logic [TIME_W-1:0] got_start;
      got_worker = beat[WKR_W-1:0];
      got_start  = beat[WKR_W +: TIME_W];
      if (grants_due.size() == 0) begin
        $error("result beat with no job outstanding: worker %0d start_time %0d",
               got_worker, got_start);
        mismatches++;
        return;
      end
      want = grants_due.pop_front();
      if (got_worker !== want.worker) begin
        $error("worker: expected %0d, got %0d", want.worker, got_worker);
        mismatches++;
      end
      if (got_start !== want.start_time) begin
        $error("start_time: expected %0d, got %0d", want.start_time, got_start);
        mismatches++;
      end
    endfunction
  endclass

  logic              clk       = 1'b0;
  logic              rst_n     = 1'b0;
  logic              in_tvalid = 1'b0;
  logic              in_tready;
  logic [DUR_W-1:0]  in_tdata  = '0;
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [BEAT_W-1:0] out_tdata;
  logic              cfg_wen   = 1'b0;
  logic [CNT_W-1:0]  cfg_wdata = '0;

  // hold_req: ask the result side for a long stall
  bit          hold_req;
  int unsigned burst_left;
  int unsigned count_writes;
  int unsigned hold_count;
  int unsigned quiet_cycles;

  dispatch_scoreboard sb = new();

  earliest_free_worker_scheduler_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),     // duration
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),    // worker, start_time
    .cfg_wen    (cfg_wen),
    .cfg_wdata  (cfg_wdata)     // worker_count
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // results are matched before the same edge's job is noted
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) sb.match_grant(out_tdata);
      if (in_tvalid && in_tready) sb.take_job(in_tdata);
    end
  end

  // ends the run once nothing has moved for too long
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_wen) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("FAIL earliest_free_worker_scheduler_core");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // result side: stretches of steady, sparse, dense or alternating on-off readiness
  initial begin : result_stall_pattern
    int unsigned span, k;
    int          mode;
    @(posedge clk);
    forever begin
      if (hold_req) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
        hold_count++;
      end else begin
        mode = $urandom_range(0, 3);
        span = $urandom_range(8, 64);
        for (k = 0; k < span && !hold_req; k++) begin
          case (mode)
            0: out_tready <= 1'b1;
            1: out_tready <= ($urandom_range(0, 3) != 0);
            2: out_tready <= ($urandom_range(0, 3) == 0);
            default: out_tready <= k[1];
          endcase
          @(posedge clk);
        end
      end
    end
  end

  // mostly short durations so that equal free times and index tie-breaks occur
  function automatic logic [DUR_W-1:0] pick_duration();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return DUR_MAX;
      2, 3, 4: return $urandom_range(0, 7);
      5, 6: return $urandom_range(0, 1000);
      7: return DUR_W'(1) << $urandom_range(0, DUR_W - 1);
      default: return $urandom;
    endcase
  endfunction

  // one job beat, offered in bursts with random gaps between them
  task automatic push_job(input logic [DUR_W-1:0] duration);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata  <= duration;
    do @(posedge clk); while (!in_tready);
  endtask

  // wait until every grant has come back and the last sift has finished
  task automatic settle();
    in_tvalid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (sb.grants_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // only called with the block idle; the clearing pass holds in_tready low
  task automatic write_count(input logic [CNT_W-1:0] value);
    while (!in_tready) @(posedge clk);
    cfg_wen   <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_wen   <= 1'b0;
    sb.load_count(value);
    count_writes++;
  endtask

  initial begin : stimulus
    logic [DUR_W-1:0] jobs[$];
    logic [CNT_W-1:0] count;
    int unsigned      n, sent, phase;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // one worker straight out of reset
    jobs = '{32'd0, DUR_MAX, 32'd1, 32'd0};
    foreach (jobs[i]) push_job(jobs[i]);
    settle();

    // full heap: zero durations walk the index tie-break
    write_count(CNT_W'(WORKERS));
    jobs = '{32'd0, 32'd0, 32'd0, DUR_MAX, 32'hAAAA_AAAA, 32'h5555_5555,
             32'd1, 32'd2, 32'd3, 32'd0, 32'd0};
    foreach (jobs[i]) push_job(jobs[i]);
    settle();

    // a zero count behaves as one worker
    write_count('0);
    jobs = '{32'd5, 32'd0, DUR_MAX};
    foreach (jobs[i]) push_job(jobs[i]);
    settle();

    // counts beyond the heap clamp to its size
    write_count('1);
    jobs = '{32'd0, 32'd0, 32'd3};
    foreach (jobs[i]) push_job(jobs[i]);
    settle();

    write_count(CNT_W'(WORKERS + 1));
    jobs = '{32'd0, 32'd0};
    foreach (jobs[i]) push_job(jobs[i]);
    settle();

    // random phases, each under a fresh worker count
    sent  = 0;
    phase = 0;
    while (sent < RANDOM_JOBS) begin
      case ($urandom_range(0, 7))
        0: count = CNT_W'(1);
        1: count = CNT_W'(2);
        2: count = CNT_W'(3);
        3: count = CNT_W'(WORKERS);
        4: count = '1;
        5: count = '0;
        6: count = CNT_W'($urandom_range(0, 127));
        default: count = CNT_W'($urandom_range(1, WORKERS));
      endcase
      write_count(count);
      n = $urandom_range(40, 160);
      // long output stall so the result register and root stage back up
      if (phase == 1 || $urandom_range(0, 7) == 0) hold_req = 1'b1;
      repeat (n) push_job(pick_duration());
      settle();
      sent += n;
      phase++;
    end

    $display("run: %0d job beats over %0d worker-count settings, %0d long output holds",
             sb.jobs_seen, count_writes, hold_count);
    $display("run: counts 0 to 127 with clamping, durations from zero to full range");
    if (sb.mismatches == 0 && sb.grants_due.size() == 0) begin
      $display("PASS earliest_free_worker_scheduler_core");
    end else begin
      $display("FAIL earliest_free_worker_scheduler_core");
    end
    $finish;
  end

endmodule
